>>> hw/rtl/id3fx_pkg.sv
// ----------------------------------------------------------------------------
// id3fx_pkg
// Shared types and constants for the ID3v2.3 frame text extractor.
// ----------------------------------------------------------------------------
package id3fx_pkg;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_FHEAD  = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_SKIP   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  // Result event codes.
  localparam logic [1:0] EV_TEXT    = 2'd0;
  localparam logic [1:0] EV_EMPTY   = 2'd1;
  localparam logic [1:0] EV_NOT_ID3 = 2'd2;
  localparam logic [1:0] EV_TAG_END = 2'd3;

  // Field kinds, in the order of the wanted frame table.
  localparam logic [2:0] KIND_TITLE   = 3'd0;
  localparam logic [2:0] KIND_COMMENT = 3'd5;
  localparam int unsigned NUM_KINDS   = 6;

  localparam logic [31:0] WANTED_IDS [NUM_KINDS] = '{
    32'h5449_5432,  // TIT2
    32'h5450_4531,  // TPE1
    32'h5441_4C42,  // TALB
    32'h5459_4552,  // TYER
    32'h5443_4F4E,  // TCON
    32'h434F_4D4D   // COMM
  };

  localparam logic [7:0] MARK_I = 8'h49;
  localparam logic [7:0] MARK_D = 8'h44;
  localparam logic [7:0] MARK_3 = 8'h33;

  localparam logic [3:0]  HDR_LAST_IDX  = 4'd9;  // tag header and frame header are 10 bytes
  localparam logic [3:0]  SIZE_FIRST_IDX = 4'd6;
  localparam logic [31:0] TAG_HDR_LEN   = 32'd10;

  // Comment frame sub-phase.
  localparam logic [1:0] CP_LANG = 2'd0;
  localparam logic [1:0] CP_DESC = 2'd1;
  localparam logic [1:0] CP_TEXT = 2'd2;

endpackage

>>> hw/rtl/id3v2_frame_text_extractor.sv
// ----------------------------------------------------------------------------
// id3v2_frame_text_extractor
// Pulls the title, artist, album, year, genre and comment text out of an
// ID3v2.3 tag, one file byte per item.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one file byte per item, with in_file_start
// set on the first byte of each file; bytes before the first file start are
// ignored. The result channel carries at most one item per input item: a text
// byte (with its field kind and a last-of-field flag), an empty-field marker,
// a not-ID3 marker or a tag-finished marker. Most bytes give no result.
// Path: a byte waits in the input register, and its result leaves through the
// output register.
// Throughput: one byte per cycle unless the receiver stalls; every byte needs
// only compares, a shift of the frame ID or size and a counter update, all done
// in a single pass between the input register and the output register.
// Stalls: with a result waiting and stalled, an empty input register still takes
// one more byte; in_stall is high while it holds one, until the result is taken.
// Reset: the parser returns to idle and both registers empty; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module id3v2_frame_text_extractor #(
  parameter int unsigned WANTED_FRAMES = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_file_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_res,
  output logic [2:0] out_field_kind,
  output logic [7:0] out_text_byte,
  output logic       out_last_of_field
);
  import id3fx_pkg::*;

  localparam logic [2:0] FRAMES_MAX = 3'(WANTED_FRAMES);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic [3:0]  byte_count_r, byte_count_nxt;
  logic [27:0] tag_length_r, tag_length_nxt;
  logic [31:0] file_position_r, file_position_nxt;
  logic [31:0] frame_ident_r, frame_ident_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]  data_idx_r, data_idx_nxt;   // data byte index, saturating at 3
  logic [2:0]  current_kind_r, current_kind_nxt;
  logic [2:0]  frames_taken_r, frames_taken_nxt;
  logic [1:0]  comment_phase_r, comment_phase_nxt;
  logic        text_stopped_r, text_stopped_nxt;

  // Output register.
  logic       out_valid_r;
  logic [1:0] out_event_r;
  logic [2:0] out_kind_r;
  logic [7:0] out_text_r;
  logic       out_last_r;

  // Result of the byte in the input register.
  logic       res_valid;
  logic [1:0] res_event;
  logic [2:0] res_kind;
  logic [7:0] res_text;
  logic       res_last;

  logic proc;
  logic out_blocked;

  // The byte in the input register is consumed unless a result is waiting
  // and stalled.
  assign out_blocked = out_valid_r && out_stall;
  assign proc        = s1_valid_r && !out_blocked;
  assign in_stall    = s1_valid_r && out_blocked;

  // Parser step for one byte. A file start wipes the state first, and the
  // byte is then taken as header byte 0.
  always_comb begin
    phase_t      ph;
    logic [3:0]  bc;
    logic [27:0] tl;
    logic [31:0] pos;
    logic [31:0] fid;
    logic [31:0] bl;
    logic [1:0]  di;
    logic [2:0]  ck;
    logic [2:0]  ft;
    logic [1:0]  cp;
    logic        ts;
    logic [7:0]  b;
    logic        found;
    logic [2:0]  kind_hit;
    logic        last;
    logic        texting;
    logic [7:0]  mark;

    b  = s1_byte_r;
    ph = phase_r;
    bc = byte_count_r;
    tl = tag_length_r;
    pos = file_position_r;
    fid = frame_ident_r;
    bl = bytes_left_r;
    di = data_idx_r;
    ck = current_kind_r;
    ft = frames_taken_r;
    cp = comment_phase_r;
    ts = text_stopped_r;
    if (s1_start_r) begin
      ph = PH_HEADER;
      bc = '0;
      tl = '0;
      pos = '0;
      fid = '0;
      bl = '0;
      di = '0;
      ck = '0;
      ft = '0;
      cp = '0;
      ts = 1'b0;
    end

    phase_nxt         = ph;
    byte_count_nxt    = bc;
    tag_length_nxt    = tl;
    file_position_nxt = pos;
    frame_ident_nxt   = fid;
    bytes_left_nxt    = bl;
    data_idx_nxt      = di;
    current_kind_nxt  = ck;
    frames_taken_nxt  = ft;
    comment_phase_nxt = cp;
    text_stopped_nxt  = ts;

    res_valid = 1'b0;
    res_event = EV_TEXT;
    res_kind  = KIND_TITLE;
    res_text  = 8'd0;
    res_last  = 1'b0;

    found    = 1'b0;
    kind_hit = KIND_TITLE;
    for (int k = NUM_KINDS - 1; k >= 0; k--) begin
      if (fid == WANTED_IDS[k]) begin
        found    = 1'b1;
        kind_hit = 3'(k);
      end
    end

    last = (bl == 32'd1);
    texting = (ck == KIND_COMMENT) ? (cp == CP_TEXT) : (di != 2'd0);

    case (bc[1:0])
      2'd0:    mark = MARK_I;
      2'd1:    mark = MARK_D;
      default: mark = MARK_3;
    endcase

    if (ph != PH_IDLE && ph != PH_DONE) begin
      if (pos != '1) begin
        file_position_nxt = pos + 32'd1;
      end
    end

    unique case (ph)
      PH_HEADER: begin
        if (bc < 4'd3 && b != mark) begin
          phase_nxt = PH_DONE;
          res_valid = 1'b1;
          res_event = EV_NOT_ID3;
        end else begin
          if (bc >= SIZE_FIRST_IDX) begin
            tag_length_nxt = {tl[20:0], b[6:0]};
          end
          if (bc == HDR_LAST_IDX) begin
            phase_nxt      = PH_FHEAD;
            byte_count_nxt = '0;
          end else begin
            byte_count_nxt = bc + 4'd1;
          end
        end
      end
      PH_FHEAD: begin
        if (bc == 4'd0 &&
            (ft >= FRAMES_MAX || pos >= 32'(tl) + TAG_HDR_LEN || b == 8'd0)) begin
          phase_nxt = PH_DONE;
          res_valid = 1'b1;
          res_event = EV_TAG_END;
        end else if (bc != HDR_LAST_IDX) begin
          if (bc == 4'd0) begin
            frame_ident_nxt = {24'd0, b};
          end else if (bc < 4'd4) begin
            frame_ident_nxt = {fid[23:0], b};
          end else if (bc == 4'd4) begin
            bytes_left_nxt = {24'd0, b};
          end else if (bc < 4'd8) begin
            bytes_left_nxt = {bl[23:0], b};
          end
          byte_count_nxt = bc + 4'd1;
        end else begin
          // Last flag byte: the frame ID and size are complete.
          byte_count_nxt = '0;
          data_idx_nxt   = '0;
          if (!found) begin
            phase_nxt = (bl != 32'd0) ? PH_SKIP : PH_FHEAD;
          end else begin
            current_kind_nxt  = kind_hit;
            frames_taken_nxt  = ft + 3'd1;
            comment_phase_nxt = CP_LANG;
            text_stopped_nxt  = 1'b0;
            if (bl == 32'd0) begin
              // An empty wanted frame still ends its field once.
              phase_nxt        = PH_FHEAD;
              text_stopped_nxt = 1'b1;
              res_valid        = 1'b1;
              res_event        = EV_EMPTY;
              res_kind         = kind_hit;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
      end
      PH_SKIP: begin
        bytes_left_nxt = bl - 32'd1;
        if (last) begin
          phase_nxt = PH_FHEAD;
        end
      end
      PH_DATA: begin
        bytes_left_nxt = bl - 32'd1;
        if (di != 2'd3) begin
          data_idx_nxt = di + 2'd1;
        end
        if (last) begin
          phase_nxt = PH_FHEAD;
        end
        if (!ts) begin
          if (texting) begin
            res_valid = 1'b1;
            res_kind  = ck;
            if (b == 8'd0) begin
              text_stopped_nxt = 1'b1;
              res_event        = EV_EMPTY;
            end else begin
              text_stopped_nxt = last;
              res_event        = EV_TEXT;
              res_text         = b;
              res_last         = last;
            end
          end else begin
            if (ck == KIND_COMMENT) begin
              if (cp == CP_LANG) begin
                if (di == 2'd3) begin
                  comment_phase_nxt = CP_DESC;
                end
              end else if (b == 8'd0) begin
                comment_phase_nxt = CP_TEXT;
              end
            end
            if (last) begin
              text_stopped_nxt = 1'b1;
              res_valid        = 1'b1;
              res_event        = EV_EMPTY;
              res_kind         = ck;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_file_start;
    end
  end

  // Parser state advances once per consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      byte_count_r    <= '0;
      tag_length_r    <= '0;
      file_position_r <= '0;
      frame_ident_r   <= '0;
      bytes_left_r    <= '0;
      data_idx_r      <= '0;
      current_kind_r  <= '0;
      frames_taken_r  <= '0;
      comment_phase_r <= '0;
      text_stopped_r  <= 1'b0;
    end else if (proc) begin
      phase_r         <= phase_nxt;
      byte_count_r    <= byte_count_nxt;
      tag_length_r    <= tag_length_nxt;
      file_position_r <= file_position_nxt;
      frame_ident_r   <= frame_ident_nxt;
      bytes_left_r    <= bytes_left_nxt;
      data_idx_r      <= data_idx_nxt;
      current_kind_r  <= current_kind_nxt;
      frames_taken_r  <= frames_taken_nxt;
      comment_phase_r <= comment_phase_nxt;
      text_stopped_r  <= text_stopped_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_event_r <= res_event;
      out_kind_r  <= res_kind;
      out_text_r  <= res_text;
      out_last_r  <= res_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_event_r;
  assign out_field_kind    = out_kind_r;
  assign out_text_byte     = out_text_r;
  assign out_last_of_field = out_last_r;

  // A stall toward the sender only ever comes from a held byte.
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall raised with an empty input register");

  // A not-ID3 or tag-finished result always leaves the parser finished.
  a_end_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    proc && res_valid && (res_event == EV_NOT_ID3 || res_event == EV_TAG_END)
    |=> phase_r == PH_DONE)
    else $error("walk end reported but parser not finished");

  // A text byte is never the NUL that ends a field.
  a_text_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r == EV_TEXT |-> out_text_r != 8'd0)
    else $error("NUL delivered as a text byte");

  // The frame count never runs past the configured limit.
  a_frames_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frames_taken_r <= FRAMES_MAX)
    else $error("more wanted frames taken than allowed");

endmodule

>>> tb/sv/id3v2_frame_text_extractor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3v2_frame_text_extractor_tb
// Self-checking testbench for the ID3v2.3 frame text extractor. A short table
// covers the header mark checks, the syncsafe size and the empty-tag end.
// Random tag files follow: well-formed tags with random frames, text, padding
// and tag sizes, mixed with noise, broken marks, truncated files and frames
// with huge sizes. Every accepted byte goes through a predictor of the
// parser. Every result item is compared field by field with the oldest
// expected one. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module id3v2_frame_text_extractor_tb;
  import id3fx_pkg::*;

  localparam int unsigned WANTED = 6;

  // One result item, as the result channel presents it.
  typedef struct packed {
    logic [1:0] ev;
    logic [2:0] kind;
    logic [7:0] ch;
    logic       last;
  } tag_result_t;

  // How a row of the directed table is checked: no result typed in, a
  // header-level result typed in, or left to the predictor.
  typedef enum logic [1:0] {
    ROW_NONE    = 2'd0,
    ROW_RESULT  = 2'd1,
    ROW_PREDICT = 2'd2
  } row_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    row_mode_t  mode;
    logic [1:0] ev;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_file_start;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_event_res;
  logic [2:0] out_field_kind;
  logic [7:0] out_text_byte;
  logic       out_last_of_field;

  // Results predicted but not yet seen on the result channel, oldest first.
  tag_result_t pending_results[$];
  int          err_count = 0;
  int          parsed_bytes = 0;
  // While set, neither side idles nor stalls.
  bit          steady = 1'b0;
  // Bytes of the tag file being built for the random part.
  logic [7:0]  file_bytes[$];

  // Predictor state: a copy of the parser as seen from outside.
  phase_t      tag_phase;
  logic [3:0]  hdr_idx;
  logic [27:0] pred_tag_len;
  logic [31:0] byte_pos;
  logic [31:0] pred_ident;
  logic [31:0] pred_length;
  logic [31:0] remaining;
  logic [2:0]  field;
  logic [2:0]  frames_done;
  logic [1:0]  comm_step;
  logic        field_closed;

  // The directed part. The first bytes come before any file start and must be
  // ignored. Then the mark is broken at each of its three bytes in turn, and
  // bytes after a broken mark are ignored. Last, a header of all-ones version
  // and flag bytes carries a size whose bytes have only bit 7 set, so the tag
  // is empty and the first frame byte ends the walk.
  dir_row_t dir_rows [0:21] = '{
    '{8'hFF, 1'b0, ROW_NONE,    EV_TEXT},
    '{8'h00, 1'b0, ROW_NONE,    EV_TEXT},
    '{MARK_I, 1'b1, ROW_NONE,   EV_TEXT},
    '{8'h00, 1'b0, ROW_RESULT,  EV_NOT_ID3},
    '{MARK_I, 1'b0, ROW_NONE,   EV_TEXT},
    '{8'hFF, 1'b1, ROW_RESULT,  EV_NOT_ID3},
    '{MARK_I, 1'b1, ROW_NONE,   EV_TEXT},
    '{MARK_D, 1'b0, ROW_NONE,   EV_TEXT},
    '{8'hFF, 1'b0, ROW_RESULT,  EV_NOT_ID3},
    '{MARK_I, 1'b1, ROW_NONE,   EV_TEXT},
    '{MARK_D, 1'b0, ROW_NONE,   EV_TEXT},
    '{MARK_3, 1'b0, ROW_NONE,   EV_TEXT},
    '{8'hFF, 1'b0, ROW_PREDICT, EV_TEXT},
    '{8'hFF, 1'b0, ROW_PREDICT, EV_TEXT},
    '{8'hFF, 1'b0, ROW_PREDICT, EV_TEXT},
    '{8'h80, 1'b0, ROW_NONE,    EV_TEXT},
    '{8'h80, 1'b0, ROW_NONE,    EV_TEXT},
    '{8'h80, 1'b0, ROW_NONE,    EV_TEXT},
    '{8'h80, 1'b0, ROW_NONE,    EV_TEXT},
    '{8'h54, 1'b0, ROW_RESULT,  EV_TAG_END},
    '{8'h00, 1'b0, ROW_NONE,    EV_TEXT},
    '{8'hFF, 1'b0, ROW_NONE,    EV_TEXT}
  };

  id3v2_frame_text_extractor #(
    .WANTED_FRAMES(WANTED)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_file_start    (in_file_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_field_kind   (out_field_kind),
    .out_text_byte    (out_text_byte),
    .out_last_of_field(out_last_of_field)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (steady) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_tag_state();
    tag_phase    = PH_IDLE;
    hdr_idx      = '0;
    pred_tag_len = '0;
    byte_pos     = '0;
    pred_ident   = '0;
    pred_length  = '0;
    remaining    = '0;
    field        = KIND_TITLE;
    frames_done  = '0;
    comm_step    = CP_LANG;
    field_closed = 1'b0;
  endfunction

  // Advances the parser copy by one accepted byte. Returns 1 when the byte
  // gives a result item, which is then left in res.
  function automatic bit predict_tag_result(input logic [7:0] b, input logic st,
                                            output tag_result_t res);
    logic [31:0] pos;
    logic [31:0] idx;
    logic [7:0]  mark;
    bit          at_last;
    bit          texting;
    int          k;
    res = '{EV_TEXT, KIND_TITLE, 8'h00, 1'b0};
    if (st) begin
      clear_tag_state();
      tag_phase = PH_HEADER;
    end
    if (tag_phase == PH_IDLE || tag_phase == PH_DONE) begin
      return 1'b0;
    end
    pos = byte_pos;
    if (byte_pos != 32'hFFFF_FFFF) begin
      byte_pos = byte_pos + 32'd1;
    end
    case (tag_phase)
      PH_HEADER: begin
        case (hdr_idx)
          4'd0:    mark = MARK_I;
          4'd1:    mark = MARK_D;
          default: mark = MARK_3;
        endcase
        if (hdr_idx < 4'd3 && b != mark) begin
          tag_phase = PH_DONE;
          res.ev = EV_NOT_ID3;
          return 1'b1;
        end
        // Syncsafe size: seven bits from each of the last four header bytes.
        if (hdr_idx >= SIZE_FIRST_IDX) begin
          pred_tag_len = {pred_tag_len[20:0], b[6:0]};
        end
        if (hdr_idx == HDR_LAST_IDX) begin
          tag_phase = PH_FHEAD;
          hdr_idx = '0;
        end else begin
          hdr_idx = hdr_idx + 4'd1;
        end
        return 1'b0;
      end
      PH_FHEAD: begin
        if (hdr_idx == 4'd0) begin
          // The walk ends at a frame start: frame quota reached, tag size
          // used up, or padding.
          if (frames_done >= WANTED || pos >= {4'h0, pred_tag_len} + TAG_HDR_LEN ||
              b == 8'h00) begin
            tag_phase = PH_DONE;
            res.ev = EV_TAG_END;
            return 1'b1;
          end
          pred_ident = '0;
          pred_length = '0;
        end
        if (hdr_idx < 4'd4) begin
          pred_ident = {pred_ident[23:0], b};
        end else if (hdr_idx < 4'd8) begin
          pred_length = {pred_length[23:0], b};
        end
        if (hdr_idx != HDR_LAST_IDX) begin
          hdr_idx = hdr_idx + 4'd1;
          return 1'b0;
        end
        hdr_idx = '0;
        remaining = pred_length;
        k = 0;
        while (k < NUM_KINDS && pred_ident != WANTED_IDS[k]) begin
          k++;
        end
        if (k == NUM_KINDS) begin
          tag_phase = (pred_length != 32'd0) ? PH_SKIP : PH_FHEAD;
          return 1'b0;
        end
        field = 3'(k);
        frames_done = frames_done + 3'd1;
        comm_step = CP_LANG;
        field_closed = 1'b0;
        if (pred_length == 32'd0) begin
          tag_phase = PH_FHEAD;
          field_closed = 1'b1;
          res.ev = EV_EMPTY;
          res.kind = field;
          return 1'b1;
        end
        tag_phase = PH_DATA;
        return 1'b0;
      end
      PH_SKIP: begin
        remaining = remaining - 32'd1;
        if (remaining == 32'd0) begin
          tag_phase = PH_FHEAD;
        end
        return 1'b0;
      end
      default: begin
        idx = pred_length - remaining;
        at_last = (remaining == 32'd1);
        remaining = remaining - 32'd1;
        if (remaining == 32'd0) begin
          tag_phase = PH_FHEAD;
        end
        if (field_closed) begin
          return 1'b0;
        end
        res.kind = field;
        if (field != KIND_COMMENT) begin
          texting = (idx >= 32'd1);
        end else begin
          texting = (comm_step == CP_TEXT);
        end
        if (texting) begin
          if (b == 8'h00) begin
            field_closed = 1'b1;
            res.ev = EV_EMPTY;
            return 1'b1;
          end
          field_closed = at_last;
          res.ev = EV_TEXT;
          res.ch = b;
          res.last = at_last;
          return 1'b1;
        end
        // Comment frames: encoding and language first, then the description
        // up to its NUL.
        if (field == KIND_COMMENT) begin
          if (comm_step == CP_LANG) begin
            if (idx >= 32'd3) begin
              comm_step = CP_DESC;
            end
          end else if (b == 8'h00) begin
            comm_step = CP_TEXT;
          end
        end
        if (at_last) begin
          field_closed = 1'b1;
          res.ev = EV_EMPTY;
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Offers one item on the input channel and returns at the edge where it is
  // taken. An idle gap, if any, comes first with valid low.
  task automatic drive_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_file_start <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic st);
    tag_result_t res;
    drive_byte(b, st);
    // Bytes that the parser ignores do not count toward the random total.
    if (st || (tag_phase != PH_IDLE && tag_phase != PH_DONE)) begin
      parsed_bytes++;
    end
    if (predict_tag_result(b, st, res)) begin
      pending_results.push_back(res);
    end
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int j = 3; j >= 0; j--) begin
      file_bytes.push_back(w[8*j +: 8]);
    end
  endtask

  // Builds one random file into file_bytes. Most files are well-formed tags
  // with random frames; the rest are noise, broken marks, cut-off files or
  // files with a frame of huge size.
  task automatic build_tag_file();
    int          roll;
    int          nf;
    int          body_len;
    int          walk_len;
    int          pad;
    int          desc_end;
    logic [31:0] id;
    logic [31:0] fsize;
    logic [27:0] tag_len;
    logic [7:0]  body[$];
    bit          huge;
    file_bytes.delete();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 6)) file_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (roll < 14) begin
      file_bytes.push_back(MARK_I);
      file_bytes.push_back(MARK_D);
      file_bytes.push_back(MARK_3);
      roll = $urandom_range(0, 2);
      file_bytes[roll] = file_bytes[roll] ^ 8'($urandom_range(1, 255));
      repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end

    file_bytes.push_back(MARK_I);
    file_bytes.push_back(MARK_D);
    file_bytes.push_back(MARK_3);
    repeat (3) file_bytes.push_back(8'($urandom_range(0, 255)));
    // The size bytes are filled in once the frames are known.
    repeat (4) file_bytes.push_back(8'h00);

    nf = $urandom_range(0, 8);
    huge = 1'b0;
    for (int f = 0; f < nf && !huge; f++) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        id = WANTED_IDS[$urandom_range(0, NUM_KINDS - 1)];
      end else if (roll < 88) begin
        // One bit away from a wanted ID, so it must be skipped.
        id = WANTED_IDS[$urandom_range(0, NUM_KINDS - 1)] ^
             (32'h1 << $urandom_range(0, 31));
      end else begin
        id = {8'($urandom_range(1, 255)), 24'($urandom)};
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        body_len = 0;
      end else if (roll < 78) begin
        body_len = $urandom_range(1, 10);
      end else if (roll < 97) begin
        body_len = $urandom_range(11, 40);
      end else begin
        body_len = $urandom_range(100, 300);
      end
      fsize = 32'(body_len);
      if ($urandom_range(0, 99) < 3) begin
        // A size far beyond the file: only a few data bytes follow, and the
        // next file start has to restart the parser mid-frame.
        huge = 1'b1;
        fsize = $urandom | 32'h0100_0000;
        body_len = $urandom_range(0, 5);
      end
      put_word(id);
      put_word(fsize);
      repeat (2) file_bytes.push_back(8'($urandom_range(0, 255)));

      body.delete();
      repeat (body_len) body.push_back(8'($urandom_range(1, 255)));
      // The encoding byte and the language bytes may take any value.
      for (int j = 0; j < 4 && j < body_len; j++) begin
        body[j] = 8'($urandom_range(0, 255));
      end
      if (id == WANTED_IDS[KIND_COMMENT]) begin
        desc_end = 4 + $urandom_range(0, 6);
        if (desc_end < body_len && $urandom_range(0, 4) != 0) begin
          body[desc_end] = 8'h00;
        end
      end
      // A NUL somewhere in the text ends the field early.
      if (body_len > 1 && $urandom_range(0, 3) == 0) begin
        body[$urandom_range(1, body_len - 1)] = 8'h00;
      end
      foreach (body[j]) file_bytes.push_back(body[j]);
    end

    walk_len = file_bytes.size() - 10;
    pad = 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      pad = $urandom_range(0, 6);
      tag_len = 28'(walk_len + pad);
    end else if (roll < 85) begin
      tag_len = 28'(walk_len);
    end else if (roll < 95) begin
      tag_len = 28'($urandom_range(0, walk_len));
    end else begin
      tag_len = 28'($urandom);
    end
    // Bit 7 of each size byte is noise that the parser must ignore.
    for (int j = 0; j < 4; j++) begin
      file_bytes[6 + j] = {1'($urandom_range(0, 1)), tag_len[21 - 7*j +: 7]};
    end
    if (!huge) begin
      repeat (pad) file_bytes.push_back(8'h00);
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 6) begin
        roll = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > roll) void'(file_bytes.pop_back());
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, name, want, want, got, got);
      err_count++;
    end
  endtask

  // Result checker. Outputs and out_stall are sampled at the rising edge,
  // before any of this edge's updates.
  always @(posedge clk) begin
    tag_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual ev=%0d kind=%0d byte=0x%h last=%0d",
                 $time, out_event_res, out_field_kind, out_text_byte, out_last_of_field);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", want.ev, out_event_res);
        check_field("field_kind", want.kind, out_field_kind);
        check_field("text_byte", want.ch, out_text_byte);
        check_field("last_of_field", want.last, out_last_of_field);
      end
    end
  end

  // Receiver: free stretches alternate with stalls of random length.
  initial begin
    int run;
    forever begin
      run = $urandom_range(1, 24);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      run = pick_gap();
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  // Stimulus: reset, the directed table, then random files until enough
  // parsed bytes have gone in.
  initial begin
    tag_result_t res;
    bit          got;
    in_valid      <= 1'b0;
    in_data_byte  <= 8'h00;
    in_file_start <= 1'b0;
    clear_tag_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      drive_byte(dir_rows[i].data, dir_rows[i].start);
      got = predict_tag_result(dir_rows[i].data, dir_rows[i].start, res);
      case (dir_rows[i].mode)
        ROW_RESULT:  pending_results.push_back(
                       tag_result_t'{dir_rows[i].ev, KIND_TITLE, 8'h00, 1'b0});
        ROW_PREDICT: if (got) pending_results.push_back(res);
        default: ;
      endcase
    end

    while (parsed_bytes < 1100) begin
      // Some files run with no idling at all on either side.
      steady = ($urandom_range(0, 6) == 0);
      build_tag_file();
      foreach (file_bytes[i]) feed_byte(file_bytes[i], i == 0);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Wait until every expected result has been seen, then leave time for any
    // late, unexpected item.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("id3v2_frame_text_extractor verification clean");
    end else begin
      $display("id3v2_frame_text_extractor verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("id3v2_frame_text_extractor verification failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/id3fx_pkg.sv
hw/rtl/id3v2_frame_text_extractor.sv
tb/sv/id3v2_frame_text_extractor_tb.sv
